>>> src/generational_handle_pool_top_assert.svh
// Assertion macros used by the handle pool datapath (ghp_datapath).
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef GENERATIONAL_HANDLE_POOL_TOP_ASSERT_SVH
`define GENERATIONAL_HANDLE_POOL_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define GHP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define GHP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GHP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ghp_pkg.sv
// Shared types and constants of the generational handle pool.
// No dependencies; used by ghp_ctrl, ghp_datapath and the top level.
package ghp_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int GEN_BITS   = 16;
   localparam int REF_BITS   = 16;
   localparam int ID_BITS    = 7;
   localparam int IDX_BITS   = $clog2(SLOT_COUNT);
   localparam int CNT_BITS   = $clog2(SLOT_COUNT + 1);

   typedef enum logic [2:0] {
      OP_ALLOC   = 3'd0,
      OP_RETAIN  = 3'd1,
      OP_RELEASE = 3'd2,
      OP_CHECK   = 3'd3,
      OP_CLEAR   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_WAIT,
      S_SLOT_WAIT,
      S_CLEAR
   } state_type;

   typedef struct packed {
      logic [2:0]          opcode;
      logic [ID_BITS-1:0]  handle_id;
      logic [GEN_BITS-1:0] handle_generation;
      logic                clear_keep;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [ID_BITS-1:0]  out_id;
      logic [GEN_BITS-1:0] out_generation;
      logic [REF_BITS-1:0] ref_count;
      logic                slot_freed;
   } rsp_type;

   typedef struct packed {
      logic                alive;
      logic [REF_BITS-1:0] refs;
      logic [GEN_BITS-1:0] gen;
   } slot_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic pop;
      logic fresh;
      logic look;
      logic resolve_pop;
      logic execute;
      logic clear_start;
      logic clear_step;
      logic clear_finish;
      logic reject_full;
      logic reject_invalid;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] op;
      logic       stack_empty;
      logic       pool_full;
      logic       handle_in_range;
      logic       clear_done;
   } dp_stat_type;

endpackage

>>> src/generational_handle_pool_top.sv
// Top level of the generational handle pool.
// Depends on ghp_pkg, ghp_ctrl and ghp_datapath.
//
// A transaction is taken when start is high and busy is low; its result is shown on rsp for
// exactly one cycle with rsp_strobe, and the receiver cannot hold it off. Allocation of a
// never-used slot and every transaction rejected before any memory access (pool full, a
// null handle id or one beyond the slots in use, unknown opcode) leave busy low, so the
// next transaction may follow at once. Retain, release and check of an in-range handle id
// first read the slot memory; retain and release then write it back, and a stale or dead
// handle is only rejected after that read. Allocation from the free list reads the free
// list, then the slot, then writes the slot. Clear sweeps the slots in use, one slot memory
// read-modify-write retiring per cycle. The result is registered and appears in the cycle
// after the transaction's last cycle. Slot state after reset comes from per-slot valid bits,
// so there is no clearing pass.
module generational_handle_pool_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ghp_pkg::req_type req,
   output logic             rsp_strobe,
   output ghp_pkg::rsp_type rsp
);
   import ghp_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   ghp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   ghp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

endmodule

>>> src/ghp_ctrl.sv
// Controller state machine of the handle pool.
// Depends on ghp_pkg; drives ghp_datapath through command and status structs.
module ghp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ghp_pkg::dp_stat_type  stat,
   output ghp_pkg::ctrl_cmd_type cmd,
   output logic                  busy
);
   import ghp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (stat.op) inside
                  OP_ALLOC: begin
                     if (!stat.stack_empty) begin
                        cmd.pop  = 1'b1;
                        state_in = S_POP_WAIT;
                     end else if (!stat.pool_full) begin
                        cmd.fresh = 1'b1;
                     end else begin
                        cmd.reject_full = 1'b1;
                     end
                  end
                  OP_RETAIN, OP_RELEASE, OP_CHECK: begin
                     if (stat.handle_in_range) begin
                        cmd.look = 1'b1;
                        state_in = S_SLOT_WAIT;
                     end else begin
                        cmd.reject_invalid = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.clear_start = 1'b1;
                     state_in        = S_CLEAR;
                  end
                  default: begin
                     cmd.reject_invalid = 1'b1;
                  end
               endcase
            end
         end
         S_POP_WAIT: begin
            cmd.resolve_pop = 1'b1;
            state_in        = S_SLOT_WAIT;
         end
         S_SLOT_WAIT: begin
            cmd.execute = 1'b1;
            state_in    = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               cmd.clear_finish = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> src/ghp_datapath.sv
// Datapath of the handle pool: slot memory, free stack, counters and result register.
// Depends on ghp_pkg and the assertion macro header; driven by ghp_ctrl.
`include "generational_handle_pool_top_assert.svh"

module ghp_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ghp_pkg::req_type      req,
   input  ghp_pkg::ctrl_cmd_type cmd,
   output ghp_pkg::dp_stat_type  stat,
   output logic                  rsp_strobe,
   output ghp_pkg::rsp_type      rsp
);
   import ghp_pkg::*;

   localparam logic [REF_BITS-1:0] REF_MAX = '1;

   req_type             req_ff;
   logic [CNT_BITS-1:0] free_depth_ff, free_depth_in;
   logic [CNT_BITS-1:0] slots_used_ff, slots_used_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;

   // Slot memory with one valid bit per entry; an entry never written reads as zero.
   slot_word_type       slot_mem [SLOT_COUNT];
   slot_word_type       slot_rdata_ff;
   logic                slot_rvalid_ff;
   logic [SLOT_COUNT-1:0] slot_valid_ff;
   logic                slot_rd_en;
   logic [IDX_BITS-1:0] slot_raddr;
   logic                slot_wr_en;
   logic [IDX_BITS-1:0] slot_waddr;
   slot_word_type       slot_wdata;

   logic [IDX_BITS-1:0] stack_mem [SLOT_COUNT];
   logic [IDX_BITS-1:0] stack_rdata_ff;
   logic                stack_rd_en;
   logic [IDX_BITS-1:0] stack_raddr;
   logic                stack_wr_en;
   logic [IDX_BITS-1:0] stack_waddr;
   logic [IDX_BITS-1:0] stack_wdata;

   logic [CNT_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic                clr_pend_ff, clr_pend_in;
   logic [IDX_BITS-1:0] clr_widx_ff, clr_widx_in;
   logic                clr_issue;

   rsp_type             rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   slot_word_type       word;
   logic                handle_ok;
   logic [IDX_BITS-1:0] hid_idx;

   assign hid_idx   = IDX_BITS'(req.handle_id - 1'b1);
   assign word      = slot_rvalid_ff ? slot_rdata_ff : '0;
   assign handle_ok = word.alive && (word.gen == req_ff.handle_generation);
   assign clr_issue = (32'(clr_cnt_ff) < 32'(slots_used_ff));

   assign stat.op              = req.opcode;
   assign stat.stack_empty     = (free_depth_ff == '0);
   assign stat.pool_full       = (32'(slots_used_ff) >= SLOT_COUNT);
   assign stat.handle_in_range = (req.handle_id != '0) &&
                                 (32'(req.handle_id) <= 32'(slots_used_ff));
   assign stat.clear_done      = !clr_issue && !clr_pend_ff;

   always_comb begin
      free_depth_in = free_depth_ff;
      slots_used_in = slots_used_ff;
      idx_in        = idx_ff;
      slot_rd_en    = 1'b0;
      slot_raddr    = '0;
      slot_wr_en    = 1'b0;
      slot_waddr    = '0;
      slot_wdata    = '0;
      stack_rd_en   = 1'b0;
      stack_raddr   = '0;
      stack_wr_en   = 1'b0;
      stack_waddr   = '0;
      stack_wdata   = '0;
      clr_cnt_in    = clr_cnt_ff;
      clr_pend_in   = clr_pend_ff;
      clr_widx_in   = clr_widx_ff;
      rsp_in        = '0;
      rsp_strobe_in = 1'b0;

      if (cmd.pop) begin
         stack_rd_en   = 1'b1;
         stack_raddr   = IDX_BITS'(free_depth_ff - 1'b1);
         free_depth_in = free_depth_ff - 1'b1;
      end

      if (cmd.look) begin
         slot_rd_en = 1'b1;
         slot_raddr = hid_idx;
         idx_in     = hid_idx;
      end

      if (cmd.resolve_pop) begin
         slot_rd_en = 1'b1;
         slot_raddr = stack_rdata_ff;
         idx_in     = stack_rdata_ff;
      end

      // A never-used slot starts at generation zero.
      if (cmd.fresh) begin
         slot_wr_en           = 1'b1;
         slot_waddr           = IDX_BITS'(slots_used_ff);
         slot_wdata.alive     = 1'b1;
         slot_wdata.refs      = REF_BITS'(1);
         slot_wdata.gen       = '0;
         slots_used_in        = slots_used_ff + 1'b1;
         rsp_strobe_in        = 1'b1;
         rsp_in.status        = STATUS_OK;
         rsp_in.out_id        = ID_BITS'(32'(slots_used_ff) + 1);
         rsp_in.ref_count     = REF_BITS'(1);
      end

      if (cmd.reject_full) begin
         rsp_strobe_in = 1'b1;
         rsp_in.status = STATUS_FULL;
      end

      if (cmd.reject_invalid) begin
         rsp_strobe_in = 1'b1;
         rsp_in.status = STATUS_INVALID;
      end

      if (cmd.execute) begin
         rsp_strobe_in = 1'b1;
         if (req_ff.opcode == OP_ALLOC) begin
            slot_wr_en            = 1'b1;
            slot_waddr            = idx_ff;
            slot_wdata.alive      = 1'b1;
            slot_wdata.refs       = REF_BITS'(1);
            slot_wdata.gen        = word.gen;
            rsp_in.status         = STATUS_OK;
            rsp_in.out_id         = ID_BITS'(32'(idx_ff) + 1);
            rsp_in.out_generation = word.gen;
            rsp_in.ref_count      = REF_BITS'(1);
         end else if (!handle_ok) begin
            rsp_in.status = STATUS_INVALID;
         end else begin
            rsp_in.status         = STATUS_OK;
            rsp_in.out_id         = req_ff.handle_id;
            rsp_in.out_generation = word.gen;
            rsp_in.ref_count      = word.refs;
            unique case (req_ff.opcode)
               OP_RETAIN: begin
                  slot_wr_en      = 1'b1;
                  slot_waddr      = idx_ff;
                  slot_wdata      = word;
                  if (word.refs != REF_MAX) begin
                     slot_wdata.refs = word.refs + 1'b1;
                  end
                  rsp_in.ref_count = slot_wdata.refs;
               end
               OP_RELEASE: begin
                  slot_wr_en = 1'b1;
                  slot_waddr = idx_ff;
                  if (word.refs > REF_BITS'(1)) begin
                     slot_wdata       = word;
                     slot_wdata.refs  = word.refs - 1'b1;
                     rsp_in.ref_count = slot_wdata.refs;
                  end else begin
                     // Last reference gone: retire this generation and recycle the index.
                     slot_wdata.alive      = 1'b0;
                     slot_wdata.refs       = '0;
                     slot_wdata.gen        = word.gen + 1'b1;
                     rsp_in.out_generation = slot_wdata.gen;
                     rsp_in.ref_count      = '0;
                     rsp_in.slot_freed     = 1'b1;
                     if (32'(free_depth_ff) < SLOT_COUNT) begin
                        stack_wr_en   = 1'b1;
                        stack_waddr   = IDX_BITS'(free_depth_ff);
                        stack_wdata   = idx_ff;
                        free_depth_in = free_depth_ff + 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (cmd.clear_start) begin
         clr_cnt_in  = '0;
         clr_pend_in = 1'b0;
      end

      // Sweep is pipelined: slot i is read while slot i-1 is written back.
      if (cmd.clear_step) begin
         clr_pend_in = clr_issue;
         if (clr_issue) begin
            slot_rd_en  = 1'b1;
            slot_raddr  = clr_cnt_ff[IDX_BITS-1:0];
            clr_widx_in = clr_cnt_ff[IDX_BITS-1:0];
            clr_cnt_in  = clr_cnt_ff + 1'b1;
         end
         if (clr_pend_ff) begin
            slot_wr_en       = 1'b1;
            slot_waddr       = clr_widx_ff;
            slot_wdata.alive = 1'b0;
            slot_wdata.refs  = '0;
            slot_wdata.gen   = word.gen + 1'b1;
            if (req_ff.clear_keep) begin
               stack_wr_en = 1'b1;
               stack_waddr = clr_widx_ff;
               stack_wdata = clr_widx_ff;
            end
         end
      end

      if (cmd.clear_finish) begin
         if (req_ff.clear_keep) begin
            free_depth_in = slots_used_ff;
         end else begin
            free_depth_in = '0;
            slots_used_in = '0;
         end
         rsp_strobe_in = 1'b1;
         rsp_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_depth_ff <= '0;
         slots_used_ff <= '0;
         clr_pend_ff   <= 1'b0;
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
         slot_valid_ff <= '0;
      end else begin
         free_depth_ff <= free_depth_in;
         slots_used_ff <= slots_used_in;
         clr_pend_ff   <= clr_pend_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (slot_wr_en) begin
            slot_valid_ff[slot_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
      end
      idx_ff      <= idx_in;
      clr_widx_ff <= clr_widx_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (slot_wr_en) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_rd_en) begin
         slot_rdata_ff  <= slot_mem[slot_raddr];
         slot_rvalid_ff <= slot_valid_ff[slot_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_wr_en) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (stack_rd_en) begin
         stack_rdata_ff <= stack_mem[stack_raddr];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   `GHP_ASSERT_ALWAYS(a_depth_le_used, 32'(free_depth_ff) <= 32'(slots_used_ff), "free list deeper than slots in use")
   `GHP_ASSERT_ALWAYS(a_used_bound, 32'(slots_used_ff) <= SLOT_COUNT, "slots in use beyond pool size")
   `GHP_ASSERT_NEXT(a_pop_depth, cmd.pop, free_depth_ff == $past(free_depth_ff) - 1'b1, "pop did not shrink free list")
   `GHP_ASSERT_IMPLIES(a_reject_zero, rsp_strobe_ff && (rsp_ff.status != STATUS_OK), (rsp_ff.out_id == '0) && (rsp_ff.ref_count == '0) && !rsp_ff.slot_freed, "rejected result carries data")

endmodule
